// ===== sv/hpk_pkg.sv =====
// Shared types and constants for the hysteresis peak picker.
// Used by every module of the block; depends on nothing else.
package hpk_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int FRAME_LEN      = 612;
  localparam int PIX_W          = 10;
  localparam int TIE_W          = 10;
  localparam int DELTA_W        = 23;
  localparam int KEY_W          = 11;
  localparam int DEF_PEAK_SLOTS = 5;
  localparam int ORIGIN_RESET   = 61;

  // APB register map, one 32-bit word per register
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_HYST_DIST    = 1'd0;
  localparam logic [APB_ADDR_W-3:0] REG_ANGLE_ORIGIN = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } pix_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] peak_height;
    logic [PIX_W-1:0]              peak_pixel;
    logic                          slot_valid;
    logic                          last_peak;
  } peak_t;

  typedef struct packed {
    logic [DELTA_W-1:0] hyst_dist;
    logic [PIX_W-1:0]   origin_mod;
  } cfg_t;

  typedef struct packed {
    logic take_item;
    logic sort_swap;
    logic emit_load;
    logic emit_last;
  } dp_cmd_t;

endpackage

// ===== sv/hpk_regs.sv =====
// APB configuration registers of the peak picker.
// Also keeps the angle origin reduced modulo the frame length. Uses hpk_pkg.
module hpk_regs
  import hpk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  localparam int MOD_STEPS = 1;
  localparam int MOD_W     = PIX_W + MOD_STEPS;

  logic [DELTA_W-1:0]    hyst_dist;
  logic [PIX_W-1:0]      angle_origin_pixel;
  logic [PIX_W-1:0]      origin_mod;
  logic                  wr_en;
  logic [APB_ADDR_W-3:0] reg_idx;

  // a 10-bit origin is below twice the frame length: one compare and subtract
  function automatic logic [PIX_W-1:0] frame_mod(input logic [PIX_W-1:0] val);
    logic [MOD_W-1:0] rem;
    logic [MOD_W-1:0] step_val;
    rem = MOD_W'(val);
    for (int s = MOD_STEPS - 1; s >= 0; s--) begin
      step_val = MOD_W'(FRAME_LEN) << s;
      if (rem >= step_val) begin
        rem = rem - step_val;
      end
    end
    return rem[PIX_W-1:0];
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_dist          <= '0;
      angle_origin_pixel <= PIX_W'(ORIGIN_RESET);
      origin_mod         <= frame_mod(PIX_W'(ORIGIN_RESET));
    end else begin
      if (wr_en) begin
        case (reg_idx)
          REG_HYST_DIST:    hyst_dist          <= pwdata[DELTA_W-1:0];
          REG_ANGLE_ORIGIN: angle_origin_pixel <= pwdata[PIX_W-1:0];
          default: ;
        endcase
      end
      origin_mod <= frame_mod(angle_origin_pixel);
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HYST_DIST:    prdata = APB_DATA_W'(hyst_dist);
      REG_ANGLE_ORIGIN: prdata = APB_DATA_W'(angle_origin_pixel);
      default:          prdata = '0;
    endcase
  end

  assign cfg.hyst_dist  = hyst_dist;
  assign cfg.origin_mod = origin_mod;

endmodule

// ===== sv/hpk_dp.sv =====
// Datapath of the peak picker: running max/min tracking, peak slots,
// angle keys for the frame-end sort and the output register. Uses hpk_pkg.
module hpk_dp
  import hpk_pkg::*;
#(
  parameter int PEAK_SLOTS = DEF_PEAK_SLOTS,
  localparam int SW = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  pix_t          pix,
  input  cfg_t          cfg,
  input  logic [SW-1:0] sel_k,
  input  logic [SW-1:0] sel_j,
  input  logic [SW-1:0] sel_best,
  input  logic [SW-1:0] sel_swap,
  output logic          key_less,
  output peak_t         peak
);

  localparam int WIDE_W = SAMPLE_BITS + 2;
  localparam logic [TIE_W-1:0] TIE_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic [PIX_W-1:0]              max_position;
  logic [TIE_W-1:0]              tie_count;
  logic                          seeking_max;
  logic [PIX_W-1:0]              pixel_counter;
  logic signed [SAMPLE_BITS-1:0] slot_height [PEAK_SLOTS];
  logic [PIX_W-1:0]              slot_pixel  [PEAK_SLOTS];
  logic [PEAK_SLOTS-1:0]         slot_used;

  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] rmax1;
  logic signed [SAMPLE_BITS-1:0] rmin1;
  logic [PIX_W-1:0]              pos1;
  logic [TIE_W-1:0]              tie1;
  logic signed [WIDE_W-1:0]      delta_w;
  logic signed [WIDE_W-1:0]      max_thr;
  logic signed [WIDE_W-1:0]      min_thr;
  logic                          confirm_max;
  logic                          confirm_min;
  logic signed [SAMPLE_BITS-1:0] eff_h [PEAK_SLOTS];
  logic signed [SAMPLE_BITS-1:0] low_val;
  logic [SW-1:0]                 low_idx;
  logic                          store;
  logic [PIX_W:0]                centre_sum;
  logic [PIX_W-1:0]              centre;
  logic [KEY_W-1:0]              key_j;
  logic [KEY_W-1:0]              key_best;

  function automatic logic [KEY_W-1:0] angle_key(input logic used,
                                                 input logic [PIX_W-1:0] pixel,
                                                 input logic [PIX_W-1:0] org);
    logic [KEY_W-1:0] key;
    if (!used) begin
      key = KEY_W'(FRAME_LEN);
    end else if (org >= pixel) begin
      key = KEY_W'(org) - KEY_W'(pixel);
    end else begin
      key = KEY_W'(org) + KEY_W'(FRAME_LEN) - KEY_W'(pixel);
    end
    return key;
  endfunction

  assign cur = pix.sample;

  always_comb begin
    if (cur > run_max) begin
      rmax1 = cur;
      pos1  = pixel_counter;
      tie1  = '0;
    end else begin
      rmax1 = run_max;
      pos1  = max_position;
      tie1  = (cur == run_max && tie_count != TIE_MAX) ? tie_count + 1'b1 : tie_count;
    end
    rmin1 = (cur < run_min) ? cur : run_min;
  end

  assign delta_w     = $signed({{(WIDE_W - DELTA_W){1'b0}}, cfg.hyst_dist});
  assign max_thr     = WIDE_W'(rmax1) - delta_w;
  assign min_thr     = WIDE_W'(rmin1) + delta_w;
  assign confirm_max = seeking_max && (WIDE_W'(cur) < max_thr);
  assign confirm_min = !seeking_max && (WIDE_W'(cur) > min_thr);

  // lowest slot, first of equals; an empty slot counts as -1
  always_comb begin
    for (int k = 0; k < PEAK_SLOTS; k++) begin
      eff_h[k] = slot_used[k] ? slot_height[k] : '1;
    end
    low_val = eff_h[0];
    low_idx = '0;
    for (int k = 1; k < PEAK_SLOTS; k++) begin
      if (eff_h[k] < low_val) begin
        low_val = eff_h[k];
        low_idx = SW'(k);
      end
    end
  end

  assign store      = confirm_max && (rmax1 > low_val);
  assign centre_sum = {1'b0, pos1} + (PIX_W + 1)'(tie1 >> 1);
  assign centre     = (centre_sum > (PIX_W + 1)'(FRAME_LEN - 1)) ?
                      PIX_W'(FRAME_LEN - 1) : centre_sum[PIX_W-1:0];

  assign key_j    = angle_key(slot_used[sel_j], slot_pixel[sel_j], cfg.origin_mod);
  assign key_best = angle_key(slot_used[sel_best], slot_pixel[sel_best], cfg.origin_mod);
  assign key_less = key_j < key_best;

  // running tracker
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max       <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      run_min       <= {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      max_position  <= '0;
      tie_count     <= '0;
      seeking_max   <= 1'b1;
      pixel_counter <= '0;
    end else if (cmd.take_item) begin
      if (pix.frame_end) begin
        run_max       <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        run_min       <= {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        max_position  <= '0;
        tie_count     <= '0;
        seeking_max   <= 1'b1;
        pixel_counter <= '0;
      end else begin
        if (pixel_counter < PIX_W'(FRAME_LEN - 1)) begin
          pixel_counter <= pixel_counter + 1'b1;
        end
        if (confirm_max) begin
          run_max      <= rmax1;
          max_position <= pos1;
          run_min      <= cur;
          tie_count    <= '0;
          seeking_max  <= 1'b0;
        end else if (confirm_min) begin
          run_max      <= cur;
          max_position <= pixel_counter;
          run_min      <= rmin1;
          tie_count    <= '0;
          seeking_max  <= 1'b1;
        end else begin
          run_max      <= rmax1;
          max_position <= pos1;
          run_min      <= rmin1;
          tie_count    <= tie1;
        end
      end
    end
  end

  // peak slots: store, swap during the sort, release after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else if (cmd.take_item && store) begin
      slot_used[low_idx] <= 1'b1;
    end else if (cmd.sort_swap) begin
      slot_used[sel_k]    <= slot_used[sel_swap];
      slot_used[sel_swap] <= slot_used[sel_k];
    end else if (cmd.emit_load && cmd.emit_last) begin
      slot_used <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item && store) begin
      slot_height[low_idx] <= rmax1;
      slot_pixel[low_idx]  <= centre;
    end else if (cmd.sort_swap) begin
      slot_height[sel_k]    <= slot_height[sel_swap];
      slot_pixel[sel_k]     <= slot_pixel[sel_swap];
      slot_height[sel_swap] <= slot_height[sel_k];
      slot_pixel[sel_swap]  <= slot_pixel[sel_k];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      peak.peak_height <= slot_used[sel_k] ? slot_height[sel_k] : '1;
      peak.peak_pixel  <= slot_used[sel_k] ? slot_pixel[sel_k] : '0;
      peak.slot_valid  <= slot_used[sel_k];
      peak.last_peak   <= cmd.emit_last;
    end
  end

endmodule

// ===== sv/hpk_ctrl.sv =====
// Controller of the peak picker: item intake, selection sort sequencing
// and result delivery. Drives the datapath through dp_cmd_t. Uses hpk_pkg.
module hpk_ctrl
  import hpk_pkg::*;
#(
  parameter int PEAK_SLOTS = DEF_PEAK_SLOTS,
  localparam int SW = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  input  logic          frame_end,
  output logic          pix_stall,
  output logic          peak_valid,
  input  logic          peak_stall,
  input  logic          key_less,
  output dp_cmd_t       cmd,
  output logic [SW-1:0] sel_k,
  output logic [SW-1:0] sel_j,
  output logic [SW-1:0] sel_best,
  output logic [SW-1:0] sel_swap
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [SW-1:0] LAST_IDX = SW'(PEAK_SLOTS - 1);
  localparam logic [SW-1:0] LAST_K   = SW'(PEAK_SLOTS - 2);

  logic [1:0]    state, state_next;
  logic [SW-1:0] k, k_next;
  logic [SW-1:0] j, j_next;
  logic [SW-1:0] best, best_next;
  logic [SW-1:0] cand;
  logic          out_free;

  assign pix_stall = (state != ST_IDLE);
  assign out_free  = !peak_valid || !peak_stall;
  assign cand      = key_less ? j : best;
  assign sel_k     = k;
  assign sel_j     = j;
  assign sel_best  = best;
  assign sel_swap  = cand;

  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    best_next  = best;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (pix_valid) begin
          cmd.take_item = 1'b1;
          if (frame_end) begin
            k_next     = '0;
            j_next     = SW'(1);
            best_next  = '0;
            state_next = (PEAK_SLOTS > 1) ? ST_SORT : ST_EMIT;
          end
        end
      end
      ST_SORT: begin
        if (j == LAST_IDX) begin
          // end of pass: move the smallest key into place, skip a self swap
          cmd.sort_swap = (cand != k);
          if (k == LAST_K) begin
            k_next     = '0;
            state_next = ST_EMIT;
          end else begin
            k_next    = SW'(32'(k) + 1);
            j_next    = SW'(32'(k) + 2);
            best_next = SW'(32'(k) + 1);
          end
        end else begin
          j_next    = SW'(32'(j) + 1);
          best_next = cand;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_last = (k == LAST_IDX);
          if (k == LAST_IDX) begin
            state_next = ST_IDLE;
          end else begin
            k_next = SW'(32'(k) + 1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= '0;
      j          <= '0;
      best       <= '0;
      peak_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      best  <= best_next;
      if (cmd.emit_load) begin
        peak_valid <= 1'b1;
      end else if (!peak_stall) begin
        peak_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/hysteresis_peak_top5_picker.sv =====
// Hysteresis peak picker, top level: ties together the APB registers,
// the controller and the datapath. Uses hpk_pkg.
//
// Each pixel item is handled when it is accepted: the running max/min tracking, the
// search for the lowest of the PEAK_SLOTS slots and the slot update all
// happen in the single accept cycle, so ordinary pixels stream at one item
// per clock outside the frame-end work. The item that carries frame_end also
// starts the frame-end work: a selection sort by angle key, one key compare
// per cycle, followed by one result item per cycle from the output register
// when the receiver does not stall. The pixel input is stalled during the
// sort and delivery. Empty slots come out last with slot_valid low and a
// height of -1.
module hysteresis_peak_top5_picker
  import hpk_pkg::*;
#(
  parameter int PEAK_SLOTS = DEF_PEAK_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pix_t                  pix_data,
  output logic                  peak_valid,
  input  logic                  peak_stall,
  output peak_t                 peak_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;

  cfg_t          cfg;
  dp_cmd_t       cmd;
  logic          key_less;
  logic [SW-1:0] sel_k;
  logic [SW-1:0] sel_j;
  logic [SW-1:0] sel_best;
  logic [SW-1:0] sel_swap;

  hpk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpk_ctrl #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .frame_end  (pix_data.frame_end),
    .pix_stall  (pix_stall),
    .peak_valid (peak_valid),
    .peak_stall (peak_stall),
    .key_less   (key_less),
    .cmd        (cmd),
    .sel_k      (sel_k),
    .sel_j      (sel_j),
    .sel_best   (sel_best),
    .sel_swap   (sel_swap)
  );

  hpk_dp #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pix      (pix_data),
    .cfg      (cfg),
    .sel_k    (sel_k),
    .sel_j    (sel_j),
    .sel_best (sel_best),
    .sel_swap (sel_swap),
    .key_less (key_less),
    .peak     (peak_data)
  );

endmodule

// ===== tb/hysteresis_peak_top5_picker_test.sv =====
// Self-checking testbench for hysteresis_peak_top5_picker: streams pixel frames,
// predicts the five sorted peaks of each frame and compares every result item.
// Depends on hpk_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module hysteresis_peak_top5_picker_test;
  import hpk_pkg::*;

  localparam int SLOTS        = DEF_PEAK_SLOTS;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 280;
  localparam longint LVL_MAX  = 8388607;
  localparam longint LVL_MIN  = -8388608;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  pix_valid  = 1'b0;
  logic                  pix_stall;
  pix_t                  pix_data   = '0;
  logic                  peak_valid;
  logic                  peak_stall = 1'b0;
  peak_t                 peak_data;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bit      pix_calm  = 1'b0;
  bit      peak_calm = 1'b0;
  bit      hold_req  = 1'b0;
  int      quiet     = 0;
  sample_t sample_q[$];

  class frame_peak_scoreboard;
    logic [DELTA_W-1:0] delta;
    logic [PIX_W-1:0]   origin;
    sample_t            run_max;
    sample_t            run_min;
    logic [PIX_W-1:0]   max_pos;
    logic [PIX_W-1:0]   ties;
    logic [PIX_W-1:0]   pix_idx;
    bit                 hunting_max;
    sample_t            slot_h[SLOTS];
    logic [PIX_W-1:0]   slot_p[SLOTS];
    bit                 slot_full[SLOTS];
    peak_t              due_peaks[$];
    int                 errors;

    function new();
      delta  = '0;
      origin = PIX_W'(ORIGIN_RESET);
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      run_max     = S_MIN;
      run_min     = S_MAX;
      max_pos     = '0;
      ties        = '0;
      pix_idx     = '0;
      hunting_max = 1'b1;
      for (int k = 0; k < SLOTS; k++) begin
        slot_h[k]    = -1;
        slot_p[k]    = '0;
        slot_full[k] = 1'b0;
      end
    endfunction

    function void write_reg(logic [APB_ADDR_W-3:0] idx, logic [APB_DATA_W-1:0] val);
      case (idx)
        REG_HYST_DIST:    delta  = val[DELTA_W-1:0];
        REG_ANGLE_ORIGIN: origin = val[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    // empty slots get a key past every real angle so they sort last
    function int angle_key(int k);
      if (!slot_full[k]) return FRAME_LEN;
      return (int'(origin) % FRAME_LEN + FRAME_LEN - int'(slot_p[k])) % FRAME_LEN;
    endfunction

    function void store_peak();
      int low;
      int centre;
      low = 0;
      for (int k = 1; k < SLOTS; k++)
        if (slot_h[k] < slot_h[low]) low = k;
      if (run_max > slot_h[low]) begin
        centre = int'(max_pos) + int'(ties) / 2;
        if (centre > FRAME_LEN - 1) centre = FRAME_LEN - 1;
        slot_h[low]    = run_max;
        slot_p[low]    = PIX_W'(centre);
        slot_full[low] = 1'b1;
      end
    endfunction

    function void note_pixel(pix_t p);
      sample_t          cur;
      logic [PIX_W-1:0] at;
      int               best;
      sample_t          th;
      logic [PIX_W-1:0] tp;
      bit               tf;
      peak_t            res;
      cur = p.sample;
      at  = pix_idx;
      if (cur > run_max) begin
        run_max = cur;
        max_pos = at;
        ties    = '0;
      end else if (cur == run_max && ties != '1) begin
        ties = ties + 1'b1;
      end
      if (cur < run_min) run_min = cur;
      if (hunting_max) begin
        if (longint'(cur) < longint'(run_max) - longint'(delta)) begin
          store_peak();
          run_min     = cur;
          ties        = '0;
          hunting_max = 1'b0;
        end
      end else if (longint'(cur) > longint'(run_min) + longint'(delta)) begin
        run_max     = cur;
        max_pos     = at;
        ties        = '0;
        hunting_max = 1'b1;
      end
      if (pix_idx < FRAME_LEN - 1) pix_idx = pix_idx + 1'b1;
      if (!p.frame_end) return;
      // selection sort by angle key, swapping at every position
      for (int k = 0; k < SLOTS; k++) begin
        best = k;
        for (int j = k + 1; j < SLOTS; j++)
          if (angle_key(j) < angle_key(best)) best = j;
        th = slot_h[k];    tp = slot_p[k];    tf = slot_full[k];
        slot_h[k]    = slot_h[best];
        slot_p[k]    = slot_p[best];
        slot_full[k] = slot_full[best];
        slot_h[best] = th; slot_p[best] = tp; slot_full[best] = tf;
      end
      for (int k = 0; k < SLOTS; k++) begin
        res.peak_height = slot_h[k];
        res.peak_pixel  = slot_full[k] ? slot_p[k] : '0;
        res.slot_valid  = slot_full[k];
        res.last_peak   = (k == SLOTS - 1);
        due_peaks.push_back(res);
      end
      clear_frame();
    endfunction

    function void check_peak(peak_t got);
      peak_t want;
      if (due_peaks.size() == 0) begin
        $error("peak item with none expected: height %0d pixel %0d",
               got.peak_height, got.peak_pixel);
        errors++;
        return;
      end
      want = due_peaks.pop_front();
      if (got.peak_height !== want.peak_height) begin
        $error("peak_height: expected %0d, got %0d", want.peak_height, got.peak_height);
        errors++;
      end
      if (got.peak_pixel !== want.peak_pixel) begin
        $error("peak_pixel: expected %0d, got %0d", want.peak_pixel, got.peak_pixel);
        errors++;
      end
      if (got.slot_valid !== want.slot_valid) begin
        $error("slot_valid: expected %0b, got %0b", want.slot_valid, got.slot_valid);
        errors++;
      end
      if (got.last_peak !== want.last_peak) begin
        $error("last_peak: expected %0b, got %0b", want.last_peak, got.last_peak);
        errors++;
      end
    endfunction

    function int pending();
      return due_peaks.size();
    endfunction
  endclass

  frame_peak_scoreboard sb;

  hysteresis_peak_top5_picker dut (.*);

  always #2 clk = ~clk;

  task automatic apb_write(input logic [APB_ADDR_W-3:0] idx,
                           input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic new_settings();
    logic [DELTA_W-1:0] d;
    logic [PIX_W-1:0]   o;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      2:       d = DELTA_W'($urandom);
      3, 4:    d = DELTA_W'($urandom_range(0, 100000));
      default: d = DELTA_W'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 7))
      0:       o = '0;
      1:       o = PIX_W'(FRAME_LEN - 1);
      2:       o = PIX_W'(FRAME_LEN);
      3:       o = '1;
      4:       o = PIX_W'(ORIGIN_RESET);
      default: o = PIX_W'($urandom);
    endcase
    apb_write(REG_HYST_DIST, APB_DATA_W'(d));
    apb_write(REG_ANGLE_ORIGIN, APB_DATA_W'(o));
  endtask

  // mostly hills and valleys around the hysteresis distance, with plateaus
  // and stray full-range samples; noisy frames are full-range throughout
  function automatic void build_frame(int len, bit noisy, longint d);
    longint      lvl;
    longint      stepv;
    int          dir;
    logic [31:0] rnd;
    sample_q.delete();
    lvl = longint'($urandom_range(0, 4000)) - 2000;
    dir = 1;
    for (int n = 0; n < len; n++) begin
      rnd = $urandom;
      if (noisy || rnd[31:25] < 10) begin
        lvl = longint'(sample_t'(rnd[23:0]));
      end else if (rnd[31:25] >= 40) begin
        if ($urandom_range(0, 9) < 6) dir = -dir;
        stepv = d * longint'($urandom_range(0, 6)) / 4 + longint'($urandom_range(0, 3));
        lvl = lvl + dir * stepv;
        if (lvl > LVL_MAX) lvl = LVL_MAX;
        if (lvl < LVL_MIN) lvl = LVL_MIN;
      end
      sample_q.push_back(sample_t'(lvl));
    end
  endfunction

  task automatic send_frame();
    pix_t p;
    int   gap;
    for (int n = 0; n < sample_q.size(); n++) begin
      p.sample    = sample_q[n];
      p.frame_end = (n == sample_q.size() - 1);
      gap = pix_calm ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
        @(negedge clk);
        pix_valid <= 1'b0;
      end
      @(negedge clk);
      pix_valid <= 1'b1;
      pix_data  <= p;
      do @(posedge clk); while (pix_stall);
      sb.note_pixel(p);
    end
  endtask

  // hold the pixel side until every peak item has come out
  task automatic drain();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int sent;
    int phase;
    int nframes;
    int len;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes, plateau, peak not above -1
    sample_q = '{0, S_MAX, S_MAX, S_MAX, S_MIN, -1, -1, -2, 5, 3};
    send_frame();
    sample_q = '{S_MIN};
    send_frame();
    drain();
    apb_write(REG_HYST_DIST, APB_DATA_W'({DELTA_W{1'b1}}));
    apb_write(REG_ANGLE_ORIGIN, APB_DATA_W'({PIX_W{1'b1}}));
    sample_q = '{S_MAX, -1, 100, S_MIN};
    send_frame();
    drain();
    apb_write(REG_HYST_DIST, '0);
    apb_write(REG_ANGLE_ORIGIN, '0);
    // six peaks: the last one evicts the lowest
    sample_q = '{10, 0, 20, 0, 30, 0, 40, 0, 50, 0, 60, 0};
    send_frame();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      new_settings();
      pix_calm  = ($urandom_range(0, 3) == 0);
      peak_calm = ($urandom_range(0, 3) == 0);
      nframes   = $urandom_range(1, 4);
      if (phase == 0) begin
        // long receiver hold-off while pixels keep coming
        hold_req = 1'b1;
        pix_calm = 1'b1;
        nframes  = 4;
      end
      repeat (nframes) begin
        if (sent < RANDOM_ITEMS) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 30);
          if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
          build_frame(len, $urandom_range(0, 6) == 0, longint'(sb.delta));
          send_frame();
          sent += len;
        end
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("hysteresis_peak_top5_picker_test OK");
    else
      $display("hysteresis_peak_top5_picker_test NOT OK");
    $finish;
  end

  initial begin
    int n;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = peak_calm ? 0 : $urandom_range(0, 11);
      end
      repeat (n) begin
        @(negedge clk);
        peak_stall <= 1'b1;
      end
      @(negedge clk);
      peak_stall <= 1'b0;
      do @(posedge clk); while (!peak_valid);
      sb.check_peak(peak_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (peak_valid && !peak_stall) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("hysteresis_peak_top5_picker_test NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
